@@ rtl/qse_pkg.sv @@
// shared constants and types for the quicksort engine
package qse_pkg;

   // default capacity of the value store
   localparam int MAX_ITEMS_DEF = 64;

   // width of one stored value
   localparam int VALUE_W = 32;

   // width of the result side tuser (overflowed flag)
   localparam int RSP_USER_W = 1;

   // sequencer states
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SORT_INIT,
      ST_POP,
      ST_POP_WAIT,
      ST_PIV_RD,
      ST_PIV_LD,
      ST_J_RD,
      ST_J_CMP,
      ST_SW_A,
      ST_SW_B,
      ST_PUSH_L,
      ST_PUSH_H,
      ST_EM_RD,
      ST_EM_LD,
      ST_EM_WAIT
   } state_type;

endpackage

@@ rtl/qse_ram.sv @@
// generic single write port, single read port ram with registered read
module qse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, old data on a same address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/quicksort_engine.sv @@
// quicksort engine top level: load, lomuto partition sequencer, ordered emit
//
//  channel   direction  tdata                     tlast        tuser
//  req_      in         item_value [31:0]         last_item    -
//  rsp_      out        sorted_value [31:0]       last_result  overflowed [0]
//
// load takes one item per cycle into the value store; req_tready is low from
// the item marked last until the final result transaction is taken.
// sorting uses one compare unit on one store read port: a partition reads the
// pivot, scans its elements and swaps each one that goes left of the boundary.
// each result goes through a store read, a load of the output register and the transaction;
// rsp_tready low holds the output register and stops the sequencer.
// reset is synchronous; the stores are not cleared and need no clearing pass.
module quicksort_engine #(
   parameter int MAX_ITEMS = qse_pkg::MAX_ITEMS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // item_value [31:0]
   input  logic [qse_pkg::VALUE_W-1:0]      req_tdata,
   input  logic                             req_tlast,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // sorted_value [31:0]
   output logic [qse_pkg::VALUE_W-1:0]      rsp_tdata,
   // overflowed [0]
   output logic [qse_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                             rsp_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready
);

   localparam int IDX_W  = $clog2(MAX_ITEMS);
   localparam int IDX1_W = IDX_W + 1;
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int STK_W  = 2 * IDX_W;
   localparam int VAL_W  = qse_pkg::VALUE_W;

   qse_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] sp_ff, sp_in;
   logic             final_ff, final_in;
   logic [IDX_W-1:0] lo_ff, lo_in;
   logic [IDX_W-1:0] hi_ff, hi_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] nxt_ff, nxt_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [VAL_W-1:0] pivot_ff, pivot_in;
   logic [VAL_W-1:0] swval_ff, swval_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   // value store ram ports
   logic             vs_we;
   logic [IDX_W-1:0] vs_waddr;
   logic [VAL_W-1:0] vs_wdata;
   logic [IDX_W-1:0] vs_raddr;
   logic [VAL_W-1:0] vs_rdata;

   // range stack ram ports
   logic             st_we;
   logic [IDX_W-1:0] st_waddr;
   logic [STK_W-1:0] st_wdata;
   logic [IDX_W-1:0] st_raddr;
   logic [STK_W-1:0] st_rdata;

   // decoded conditions
   logic req_fire;
   logic rsp_fire;
   logic has_room;
   logic goes_left;
   logic push_lo_ok;
   logic push_hi_ok;
   logic stack_room;
   logic emit_last;

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;
   assign has_room   = count_ff < CNT_W'(MAX_ITEMS);
   assign stack_room = sp_ff < CNT_W'(MAX_ITEMS);
   // shared compare unit: element at j against the pivot, signed
   assign goes_left  = $signed(vs_rdata) <= $signed(pivot_ff);
   assign push_lo_ok = IDX1_W'(nxt_ff) > (IDX1_W'(lo_ff) + IDX1_W'(1));
   assign push_hi_ok = (IDX1_W'(nxt_ff) + IDX1_W'(1)) < IDX1_W'(hi_ff);
   assign emit_last  = CNT_W'(k_ff) == (count_ff - CNT_W'(1));

   qse_ram #(
      .WIDTH (VAL_W),
      .DEPTH (MAX_ITEMS)
   ) u_value_store (
      .clock   (clock),
      .wr_en   (vs_we),
      .wr_addr (vs_waddr),
      .wr_data (vs_wdata),
      .rd_addr (vs_raddr),
      .rd_data (vs_rdata)
   );

   qse_ram #(
      .WIDTH (STK_W),
      .DEPTH (MAX_ITEMS)
   ) u_range_stack (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         qse_pkg::ST_LOAD: begin
            if (req_fire && req_tlast) begin
               state_in = qse_pkg::ST_SORT_INIT;
            end
         end
         qse_pkg::ST_SORT_INIT: begin
            if (count_ff < CNT_W'(2)) begin
               state_in = qse_pkg::ST_EM_RD;
            end else begin
               state_in = qse_pkg::ST_PIV_RD;
            end
         end
         qse_pkg::ST_POP: begin
            if (sp_ff == '0) begin
               state_in = qse_pkg::ST_EM_RD;
            end else begin
               state_in = qse_pkg::ST_POP_WAIT;
            end
         end
         qse_pkg::ST_POP_WAIT: begin
            if (st_rdata[IDX_W-1:0] < st_rdata[STK_W-1:IDX_W]) begin
               state_in = qse_pkg::ST_PIV_RD;
            end else begin
               state_in = qse_pkg::ST_POP;
            end
         end
         qse_pkg::ST_PIV_RD: state_in = qse_pkg::ST_PIV_LD;
         qse_pkg::ST_PIV_LD: state_in = qse_pkg::ST_J_RD;
         qse_pkg::ST_J_RD: begin
            if (j_ff == hi_ff) begin
               state_in = qse_pkg::ST_SW_A;
            end else begin
               state_in = qse_pkg::ST_J_CMP;
            end
         end
         qse_pkg::ST_J_CMP: begin
            if (goes_left && (nxt_ff != j_ff)) begin
               state_in = qse_pkg::ST_SW_A;
            end else begin
               state_in = qse_pkg::ST_J_RD;
            end
         end
         qse_pkg::ST_SW_A: state_in = qse_pkg::ST_SW_B;
         qse_pkg::ST_SW_B: begin
            if (final_ff) begin
               state_in = qse_pkg::ST_PUSH_L;
            end else begin
               state_in = qse_pkg::ST_J_RD;
            end
         end
         qse_pkg::ST_PUSH_L: state_in = qse_pkg::ST_PUSH_H;
         qse_pkg::ST_PUSH_H: state_in = qse_pkg::ST_POP;
         qse_pkg::ST_EM_RD:  state_in = qse_pkg::ST_EM_LD;
         qse_pkg::ST_EM_LD:  state_in = qse_pkg::ST_EM_WAIT;
         qse_pkg::ST_EM_WAIT: begin
            if (rsp_fire) begin
               if (rsp_last_ff) begin
                  state_in = qse_pkg::ST_LOAD;
               end else begin
                  state_in = qse_pkg::ST_EM_RD;
               end
            end
         end
         default: state_in = qse_pkg::ST_LOAD;
      endcase
   end

   // datapath register updates
   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      sp_in        = sp_ff;
      final_in     = final_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      j_in         = j_ff;
      nxt_in       = nxt_ff;
      k_in         = k_ff;
      pivot_in     = pivot_ff;
      swval_in     = swval_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      case (state_ff)
         qse_pkg::ST_LOAD: begin
            if (req_fire) begin
               if (has_room) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         qse_pkg::ST_SORT_INIT: begin
            // whole set is the first range, no stack entry needed
            lo_in = '0;
            hi_in = IDX_W'(count_ff - CNT_W'(1));
            sp_in = '0;
            k_in  = '0;
         end
         qse_pkg::ST_POP: begin
            k_in = '0;
            if (sp_ff != '0) begin
               sp_in = sp_ff - CNT_W'(1);
            end
         end
         qse_pkg::ST_POP_WAIT: begin
            lo_in = st_rdata[IDX_W-1:0];
            hi_in = st_rdata[STK_W-1:IDX_W];
         end
         qse_pkg::ST_PIV_LD: begin
            pivot_in = vs_rdata;
            j_in     = lo_ff;
            nxt_in   = lo_ff;
            final_in = 1'b0;
         end
         qse_pkg::ST_J_RD: begin
            // end of scan: pivot swap with the boundary element
            if (j_ff == hi_ff) begin
               swval_in = pivot_ff;
               final_in = 1'b1;
            end
         end
         qse_pkg::ST_J_CMP: begin
            if (goes_left) begin
               if (nxt_ff == j_ff) begin
                  nxt_in = nxt_ff + IDX_W'(1);
                  j_in   = j_ff + IDX_W'(1);
               end else begin
                  swval_in = vs_rdata;
               end
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         qse_pkg::ST_SW_B: begin
            if (!final_ff) begin
               nxt_in = nxt_ff + IDX_W'(1);
               j_in   = j_ff + IDX_W'(1);
            end
         end
         qse_pkg::ST_PUSH_L: begin
            if (push_lo_ok && stack_room) begin
               sp_in = sp_ff + CNT_W'(1);
            end
         end
         qse_pkg::ST_PUSH_H: begin
            if (push_hi_ok && stack_room) begin
               sp_in = sp_ff + CNT_W'(1);
            end
         end
         qse_pkg::ST_EM_LD: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = vs_rdata;
            rsp_last_in  = emit_last;
            rsp_ovf_in   = ovf_ff;
         end
         qse_pkg::ST_EM_WAIT: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               k_in         = k_ff + IDX_W'(1);
               if (rsp_last_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  sp_in    = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // ram control and port outputs
   always_comb begin
      vs_we    = 1'b0;
      vs_waddr = j_ff;
      vs_wdata = vs_rdata;
      vs_raddr = hi_ff;
      st_we    = 1'b0;
      st_waddr = sp_ff[IDX_W-1:0];
      st_wdata = {nxt_ff - IDX_W'(1), lo_ff};
      st_raddr = IDX_W'(sp_ff - CNT_W'(1));
      req_tready = 1'b0;
      case (state_ff)
         qse_pkg::ST_LOAD: begin
            req_tready = 1'b1;
            vs_we      = req_tvalid && has_room;
            vs_waddr   = count_ff[IDX_W-1:0];
            vs_wdata   = req_tdata;
         end
         qse_pkg::ST_PIV_RD: vs_raddr = hi_ff;
         qse_pkg::ST_J_RD: begin
            vs_raddr = (j_ff == hi_ff) ? nxt_ff : j_ff;
         end
         qse_pkg::ST_J_CMP: vs_raddr = nxt_ff;
         qse_pkg::ST_SW_A: begin
            // old element at the boundary goes to j
            vs_we    = 1'b1;
            vs_waddr = j_ff;
            vs_wdata = vs_rdata;
         end
         qse_pkg::ST_SW_B: begin
            vs_we    = 1'b1;
            vs_waddr = nxt_ff;
            vs_wdata = swval_ff;
         end
         qse_pkg::ST_PUSH_L: begin
            st_we    = push_lo_ok && stack_room;
            st_wdata = {nxt_ff - IDX_W'(1), lo_ff};
         end
         qse_pkg::ST_PUSH_H: begin
            st_we    = push_hi_ok && stack_room;
            st_wdata = {hi_ff, nxt_ff + IDX_W'(1)};
         end
         qse_pkg::ST_EM_RD: vs_raddr = k_ff;
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = qse_pkg::RSP_USER_W'(rsp_ovf_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qse_pkg::ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         sp_ff        <= '0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         sp_ff        <= sp_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      j_ff        <= j_in;
      nxt_ff      <= nxt_in;
      k_ff        <= k_in;
      pivot_ff    <= pivot_in;
      swval_ff    <= swval_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   // loading and emitting never overlap
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted while a result is pending");

   // fill count stays within the store
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("item count beyond capacity");

   // final result transaction returns the block to loading
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && !rsp_tvalid))
      else $error("block did not return to loading after the last result");

   // partition scan never passes the pivot position
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == qse_pkg::ST_J_CMP) |-> ((j_ff < hi_ff) && (nxt_ff <= j_ff)))
      else $error("partition indexes out of order");

endmodule
